/* rtl/core/fsem_pkg.sv */
// Package with types, constants and sizes shared by the capacity semaphore.
`timescale 1ns / 1ps

package fsem_pkg;

    // Sizes of the payload fields.
    localparam int AMT_W  = 32;
    localparam int TAG_W  = 8;
    localparam int HELD_W = 33;
    localparam int KIND_W = 3;
    localparam int FUNC_W = 2;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 1;

    // Waiter queue sizing.
    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TAIL_W = QIDX_W + 1;

    // Most waiters granted by a single release.
    localparam int DRAIN_LIMIT = 8;
    localparam int DRAIN_W = $clog2(DRAIN_LIMIT + 1);

    // Command queue between the front and the back.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CAP  = 1'd1;

    // Request function codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TRY = 2'd0,
        FUNC_ACQ = 2'd1,
        FUNC_REL = 2'd2
    } func_t;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_TRY_OK   = 3'd0,
        KIND_TRY_NO   = 3'd1,
        KIND_ACQ_OK   = 3'd2,
        KIND_QUEUED   = 3'd3,
        KIND_Q_FULL   = 3'd4,
        KIND_RELEASED = 3'd5,
        KIND_WAITER   = 3'd6
    } kind_t;

    // Back-end states.
    typedef enum logic {
        BS_IDLE,
        BS_EMIT
    } bstate_t;

    // A classified command.
    typedef struct packed {
        func_t             op;
        logic [AMT_W-1:0]  amount;
        logic              amt_zero;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    // Command handed from the front to the queue.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    // Command offered by the queue to the back.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

    // One result item.
    typedef struct packed {
        kind_t             kind;
        logic [TAG_W-1:0]  tag;
        logic [HELD_W-1:0] in_use;
        logic              underflow;
        logic              last;
    } result_t;

endpackage

/* rtl/core/fsem_if.sv */
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface fsem_in_if;
    import fsem_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [AMT_W-1:0]    amount;
    logic [TAG_W-1:0]    tag;

    modport source (output valid, func, amount, tag, input ready);
    modport sink (input valid, func, amount, tag, output ready);
endinterface

interface fsem_out_if;
    import fsem_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    result_tag;
    logic [HELD_W-1:0]   in_use;
    logic                underflow;
    logic                last;

    modport source (output valid, kind, result_tag, in_use, underflow, last, input ready);
    modport sink (input valid, kind, result_tag, in_use, underflow, last, output ready);
endinterface

/* rtl/core/fsem_front.sv */
// Front end: accepts requests, drops unused codes and classifies the rest.
`timescale 1ns / 1ps

module fsem_front (
    fsem_in_if.sink         req,
    input  logic            cmdq_full,
    output fsem_pkg::cmd_push_t push
);
    import fsem_pkg::*;

    logic known;

    // Accept whenever the command queue has room.
    assign req.ready = !cmdq_full;

    // Recognize the function code.
    always_comb
    begin
        unique case (func_t'(req.func))
            FUNC_TRY: known = 1'b1;
            FUNC_ACQ: known = 1'b1;
            FUNC_REL: known = 1'b1;
            default:  known = 1'b0;
        endcase
    end

    // Build the command for the queue; unused codes vanish here.
    always_comb
    begin
        push.valid        = req.valid && !cmdq_full && known;
        push.cmd.op       = func_t'(req.func);
        push.cmd.amount   = req.amount;
        push.cmd.amt_zero = (req.amount == '0);
        push.cmd.tag      = req.tag;
    end

endmodule

/* rtl/core/fsem_cmdq.sv */
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module fsem_cmdq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsem_pkg::cmd_push_t  push,
    input  logic                 pop,
    output logic                 full,
    output fsem_pkg::cmd_head_t  head
);
    import fsem_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0] wr_ptr_reg;
    logic [CMDQ_IDX_W-1:0] wr_ptr_next;
    logic [CMDQ_IDX_W-1:0] rd_ptr_reg;
    logic [CMDQ_IDX_W-1:0] rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg;
    logic [CMDQ_CNT_W-1:0] count_next;
    logic                  do_pop;

    assign full       = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

/* rtl/core/fsem_back.sv */
// Back end: capacity accounting, waiter queue, release drain and result register.
`timescale 1ns / 1ps

module fsem_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fsem_pkg::cmd_head_t           head,
    output logic                          pop,
    input  logic                          cfg_we,
    input  logic [fsem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsem_pkg::CFG_W-1:0]    cfg_data,
    fsem_out_if.source                    rsp
);
    import fsem_pkg::*;

    // Fit rule against the current total and limit.
    function automatic logic fits(input logic [HELD_W-1:0] held,
                                  input logic [AMT_W-1:0]  amt,
                                  input logic              lim_en,
                                  input logic [AMT_W-1:0]  max_cap);
        logic [HELD_W:0] sum;
        logic            ok;
        sum = {1'b0, held} + (HELD_W + 1)'(amt);
        if (!lim_en)
            ok = 1'b1;
        else if (held == '0 && amt > max_cap)
            ok = 1'b1;
        else if (held > HELD_W'(max_cap))
            ok = 1'b0;
        else
            ok = (sum <= (HELD_W + 1)'(max_cap));
        return ok;
    endfunction

    // Add to the total, saturating at the largest value.
    function automatic logic [HELD_W-1:0] take(input logic [HELD_W-1:0] held,
                                               input logic [AMT_W-1:0]  amt);
        logic [HELD_W:0] sum;
        sum = {1'b0, held} + (HELD_W + 1)'(amt);
        return sum[HELD_W] ? '1 : sum[HELD_W-1:0];
    endfunction

    bstate_t             state_reg;
    bstate_t             state_next;
    logic                lim_en_reg;
    logic [AMT_W-1:0]    max_cap_reg;
    logic [HELD_W-1:0]   held_reg;
    logic [HELD_W-1:0]   held_next;
    logic [QIDX_W-1:0]   qhead_reg;
    logic [QIDX_W-1:0]   qhead_next;
    logic [QCNT_W-1:0]   qcount_reg;
    logic [QCNT_W-1:0]   qcount_next;
    logic [AMT_W-1:0]    wamt_reg [QUEUE_DEPTH];
    logic [TAG_W-1:0]    wtag_reg [QUEUE_DEPTH];
    logic                drain_en_reg;
    logic                drain_en_next;
    logic [DRAIN_W-1:0]  granted_reg;
    logic [DRAIN_W-1:0]  granted_next;
    result_t             pend_reg;
    result_t             pend_next;
    result_t             out_reg;
    result_t             out_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                q_wr;
    logic [QIDX_W-1:0]   q_tail;
    logic [TAIL_W-1:0]   tail_sum;
    logic [AMT_W-1:0]    head_amt;
    logic [TAG_W-1:0]    head_tag;
    logic                cmd_fits;
    logic                more;
    logic                slot_free;

    assign head_amt  = wamt_reg[qhead_reg];
    assign head_tag  = wtag_reg[qhead_reg];
    assign slot_free = !out_valid_reg || rsp.ready;
    assign cmd_fits  = (qcount_reg == '0)
                       && fits(held_reg, head.cmd.amount, lim_en_reg, max_cap_reg);
    assign more      = drain_en_reg && (qcount_reg != '0)
                       && (granted_reg < DRAIN_W'(DRAIN_LIMIT))
                       && fits(held_reg, head_amt, lim_en_reg, max_cap_reg);

    // Tail slot of the waiter ring.
    always_comb
    begin
        tail_sum = TAIL_W'(qhead_reg) + TAIL_W'(qcount_reg);
        if (tail_sum >= TAIL_W'(QUEUE_DEPTH))
            tail_sum = tail_sum - TAIL_W'(QUEUE_DEPTH);
        q_tail = tail_sum[QIDX_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (head.valid)
                    state_next = BS_EMIT;
            end
            BS_EMIT:
            begin
                if (slot_free && !more)
                    state_next = BS_IDLE;
            end
            default: state_next = BS_IDLE;
        endcase
    end

    // Datapath: command execution, drain steps and result staging.
    always_comb
    begin
        pop            = 1'b0;
        q_wr           = 1'b0;
        held_next      = held_reg;
        qhead_next     = qhead_reg;
        qcount_next    = qcount_reg;
        drain_en_next  = drain_en_reg;
        granted_next   = granted_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            BS_IDLE:
            begin
                if (head.valid)
                begin
                    pop                = 1'b1;
                    granted_next       = '0;
                    drain_en_next      = 1'b0;
                    pend_next.tag      = head.cmd.tag;
                    pend_next.underflow = 1'b0;
                    pend_next.last     = 1'b0;
                    unique case (head.cmd.op)
                        FUNC_TRY:
                        begin
                            if (cmd_fits)
                            begin
                                held_next      = take(held_reg, head.cmd.amount);
                                pend_next.kind = KIND_TRY_OK;
                            end
                            else
                            begin
                                pend_next.kind = KIND_TRY_NO;
                            end
                        end
                        FUNC_ACQ:
                        begin
                            if (cmd_fits)
                            begin
                                held_next      = take(held_reg, head.cmd.amount);
                                pend_next.kind = KIND_ACQ_OK;
                            end
                            else if (qcount_reg == QCNT_W'(QUEUE_DEPTH))
                            begin
                                pend_next.kind = KIND_Q_FULL;
                            end
                            else
                            begin
                                q_wr           = 1'b1;
                                qcount_next    = qcount_reg + 1'b1;
                                pend_next.kind = KIND_QUEUED;
                            end
                        end
                        FUNC_REL:
                        begin
                            pend_next.kind = KIND_RELEASED;
                            drain_en_next  = !head.cmd.amt_zero;
                            if (!head.cmd.amt_zero)
                            begin
                                if (held_reg < HELD_W'(head.cmd.amount))
                                begin
                                    held_next           = '0;
                                    pend_next.underflow = 1'b1;
                                end
                                else
                                begin
                                    held_next = held_reg - HELD_W'(head.cmd.amount);
                                end
                            end
                        end
                        default:
                        begin
                            pend_next.kind = KIND_TRY_NO;
                        end
                    endcase
                    pend_next.in_use = held_next;
                end
            end
            BS_EMIT:
            begin
                if (slot_free)
                begin
                    out_next       = pend_reg;
                    out_next.last  = !more;
                    out_valid_next = 1'b1;
                    if (more)
                    begin
                        held_next           = take(held_reg, head_amt);
                        pend_next.kind      = KIND_WAITER;
                        pend_next.tag       = head_tag;
                        pend_next.in_use    = held_next;
                        pend_next.underflow = 1'b0;
                        pend_next.last      = 1'b0;
                        qhead_next  = (qhead_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                      : qhead_reg + 1'b1;
                        qcount_next  = qcount_reg - 1'b1;
                        granted_next = granted_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control and accounting registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            lim_en_reg    <= 1'b0;
            max_cap_reg   <= AMT_W'(1);
            held_reg      <= '0;
            qhead_reg     <= '0;
            qcount_reg    <= '0;
            drain_en_reg  <= 1'b0;
            granted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            qhead_reg     <= qhead_next;
            qcount_reg    <= qcount_next;
            drain_en_reg  <= drain_en_next;
            granted_reg   <= granted_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LIMIT_EN: lim_en_reg  <= cfg_data[0];
                    CFG_MAX_CAP:  max_cap_reg <= cfg_data[AMT_W-1:0];
                    default:      lim_en_reg  <= lim_en_reg;
                endcase
            end
        end
    end

    // Payload registers and waiter storage.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (q_wr)
        begin
            wamt_reg[q_tail] <= head.cmd.amount;
            wtag_reg[q_tail] <= head.cmd.tag;
        end
    end

    // Result channel.
    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_reg.kind;
    assign rsp.result_tag = out_reg.tag;
    assign rsp.in_use     = out_reg.in_use;
    assign rsp.underflow  = out_reg.underflow;
    assign rsp.last       = out_reg.last;

endmodule

/* rtl/core/fifo_capacity_semaphore.sv */
// A request's first result goes through the command queue, pend_reg and out_reg.
// The back end pops a new request only after emitting all results of the last one.
// A release with waiters adds one result for each waiter it grants (at most eight).
// Reset: nothing held, waiter queue and command queue empty, limit off, max_capacity 1.
// Waiter storage is not cleared; no clearing pass is needed.
`timescale 1ns / 1ps

module fifo_capacity_semaphore (
    input  logic                           clk,
    input  logic                           rst_n,
    fsem_in_if.sink                        req,
    fsem_out_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [fsem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsem_pkg::CFG_W-1:0]     cfg_data
);
    import fsem_pkg::*;

    cmd_push_t push;
    cmd_head_t head;
    logic      cmdq_full;
    logic      pop;

    // Request classification.
    fsem_front u_front (
        .req       (req),
        .cmdq_full (cmdq_full),
        .push      (push)
    );

    // Command queue between the two halves.
    fsem_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (cmdq_full),
        .head  (head)
    );

    // Execution and results.
    fsem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule
